@@ rtl/newton_step_sym3x3_top_assert.svh @@
`ifndef NEWTON_STEP_SYM3X3_TOP_ASSERT_SVH
`define NEWTON_STEP_SYM3X3_TOP_ASSERT_SVH
// assertion helpers for the newton step block, clocked on clk, off during reset
`define NSYM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// the condition must hold in the cycle after the trigger
`define NSYM_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`endif

@@ rtl/nsym_pkg.sv @@
// ----------------------------------------------------------------------------
// nsym_pkg
// shared widths, types and operand tables of the symmetric 3x3 newton step
// ----------------------------------------------------------------------------
package nsym_pkg;

    localparam int DATA_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int COF_W    = 2 * DATA_W + 1;
    localparam int HI_W     = COF_W - DATA_W;
    localparam int LO_PW    = 2 * DATA_W + 1;
    localparam int HI_PW    = HI_W + DATA_W;
    localparam int PROD_W   = COF_W + DATA_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int MAG_W    = SUM_W;
    localparam int NUM_W    = MAG_W + FRAC_W;
    localparam int CMP_W    = MAG_W + DATA_W;
    localparam int SQ_W     = 2 * DATA_W;
    localparam int SREM_W   = DATA_W + 2;
    localparam int SQT_W    = SREM_W + 2;
    localparam int DET_W    = 2 * DATA_W;
    localparam int DET_SH   = 2 * FRAC_W;
    localparam int NPROD    = 12;
    localparam int NCOF     = 6;
    localparam int MID_DEPTH = 8;
    localparam int MID_AW   = 3;
    localparam int OUT_DEPTH = 32;
    localparam int OUT_AW   = 5;

    // cofactor order: c11 c12 c13 c22 c23 c33
    // operand order: gx gy gz a b c
    // products: det terms, then the three rows of adj(h) times g
    localparam int COF_SEL [NPROD] = '{0, 1, 2, 0, 1, 2, 1, 3, 4, 2, 4, 5};
    localparam int VAL_SEL [NPROD] = '{3, 4, 5, 0, 1, 2, 0, 1, 2, 0, 1, 2};

    typedef struct packed {
        logic [NCOF-1:0][COF_W-1:0] cof;
        logic [2:0][DATA_W-1:0]     hrow;
        logic [2:0][DATA_W-1:0]     grad;
        logic [SQ_W-1:0]            sq;
    } mid_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0]  r;
        logic [2:0][DATA_W-1:0] q;
        logic [2:0]             big;
        logic [2:0]             neg;
        logic [MAG_W-1:0]       dmag;
        logic                   sing;
        logic [DET_W-1:0]       det;
        logic [SQ_W-1:0]        sq;
        logic [SREM_W-1:0]      srem;
        logic [DATA_W-1:0]      sroot;
    } div_st_t;

    typedef struct packed {
        logic [2:0][DATA_W-1:0] step;
        logic [DATA_W-1:0]      norm;
        logic [DET_W-1:0]       det;
        logic                   sing;
    } result_t;

endpackage

@@ rtl/nsym_front.sv @@
// ----------------------------------------------------------------------------
// nsym_front
// takes items in, forms the hessian cofactors and the squared gradient norm
// ----------------------------------------------------------------------------
module nsym_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [nsym_pkg::DATA_W-1:0] grad_x,
    input  logic signed [nsym_pkg::DATA_W-1:0] grad_y,
    input  logic signed [nsym_pkg::DATA_W-1:0] grad_z,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_xx,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_xy,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_xz,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_yy,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_yz,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_zz,
    input  logic                              mid_pop,
    output logic                              mid_push,
    output nsym_pkg::mid_item_t               mid_item
);
    import nsym_pkg::*;

    logic                         acc;
    logic                         s1_vld_reg;
    logic                         s2_vld_reg;
    logic [8:0][DATA_W-1:0]       in_reg;
    logic [NPROD-1:0][SQ_W-1:0]   prod_next;
    logic [NPROD-1:0][SQ_W-1:0]   prod_reg;
    logic [2:0][SQ_W-1:0]         sqr_next;
    logic [2:0][SQ_W-1:0]         sqr_reg;
    logic [5:0][DATA_W-1:0]       pass_reg;
    logic [MID_AW:0]              cnt_reg;
    logic [MID_AW:0]              cnt_next;

    // credit covers items in flight here plus those waiting in the queue
    assign full = (cnt_reg == (MID_AW+1)'(MID_DEPTH));
    assign acc  = push && !full;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc && !mid_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!acc && mid_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        logic signed [DATA_W-1:0] a, b, c, d, e, g, gx, gy, gz;
        gx = $signed(in_reg[0]);
        gy = $signed(in_reg[1]);
        gz = $signed(in_reg[2]);
        a  = $signed(in_reg[3]);
        b  = $signed(in_reg[4]);
        c  = $signed(in_reg[5]);
        d  = $signed(in_reg[6]);
        e  = $signed(in_reg[7]);
        g  = $signed(in_reg[8]);
        prod_next[0]  = d * g;
        prod_next[1]  = e * e;
        prod_next[2]  = c * e;
        prod_next[3]  = b * g;
        prod_next[4]  = b * e;
        prod_next[5]  = c * d;
        prod_next[6]  = a * g;
        prod_next[7]  = c * c;
        prod_next[8]  = b * c;
        prod_next[9]  = a * e;
        prod_next[10] = a * d;
        prod_next[11] = b * b;
        sqr_next[0]   = gx * gx;
        sqr_next[1]   = gy * gy;
        sqr_next[2]   = gz * gz;
    end

    always_comb
    begin
        for (int k = 0; k < NCOF; k++)
        begin
            mid_item.cof[k] = {prod_reg[2*k][SQ_W-1], prod_reg[2*k]}
                            - {prod_reg[2*k+1][SQ_W-1], prod_reg[2*k+1]};
        end
        mid_item.grad = pass_reg[2:0];
        mid_item.hrow = pass_reg[5:3];
        mid_item.sq   = sqr_reg[0] + sqr_reg[1] + sqr_reg[2];
    end

    assign mid_push = s2_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            s1_vld_reg <= acc;
            s2_vld_reg <= s1_vld_reg;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            in_reg <= {hess_zz, hess_yz, hess_yy, hess_xz, hess_xy, hess_xx,
                       grad_z, grad_y, grad_x};
        end
        prod_reg <= prod_next;
        sqr_reg  <= sqr_next;
        pass_reg <= in_reg[5:0];
    end

endmodule

@@ rtl/nsym_queue.sv @@
// ----------------------------------------------------------------------------
// nsym_queue
// short queue of cofactor items between the front and the back
// ----------------------------------------------------------------------------
module nsym_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  nsym_pkg::mid_item_t   item_in,
    input  logic                  pop,
    output nsym_pkg::mid_item_t   item_out,
    output nsym_pkg::queue_stat_t stat
);
    import nsym_pkg::*;

    mid_item_t         mem_reg [MID_DEPTH];
    logic [MID_AW-1:0] wr_ptr_reg;
    logic [MID_AW-1:0] rd_ptr_reg;
    logic [MID_AW:0]   cnt_reg;
    logic [MID_AW:0]   cnt_next;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == (MID_AW+1)'(MID_DEPTH));
    assign item_out   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

@@ rtl/nsym_back.sv @@
// ----------------------------------------------------------------------------
// nsym_back
// determinant, adjugate products, pipelined divide and root, result queue
// ----------------------------------------------------------------------------
module nsym_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nsym_pkg::mid_item_t                q_item,
    input  nsym_pkg::queue_stat_t              q_stat,
    output logic                               q_pop,
    input  logic                               pop,
    output logic                               empty,
    output logic signed [nsym_pkg::DATA_W-1:0] step_x,
    output logic signed [nsym_pkg::DATA_W-1:0] step_y,
    output logic signed [nsym_pkg::DATA_W-1:0] step_z,
    output logic [nsym_pkg::DATA_W-1:0]        grad_norm,
    output logic signed [nsym_pkg::DET_W-1:0]  determinant,
    output logic                               singular
);
    import nsym_pkg::*;

    logic                          issue;
    logic                          deq;
    logic [OUT_AW:0]               crd_reg;
    logic [OUT_AW:0]               crd_next;
    logic                          v1_reg, v2_reg, v3_reg;
    logic [NPROD-1:0][LO_PW-1:0]   lo_next, lo_reg;
    logic [NPROD-1:0][HI_PW-1:0]   hi_next, hi_reg;
    logic [NPROD-1:0][PROD_W-1:0]  prod_next, prod_reg;
    logic [3:0][SUM_W-1:0]         sum_next, sum_reg;
    logic [SQ_W-1:0]               sq1_reg, sq2_reg, sq3_reg;
    div_st_t                       pre_next;
    div_st_t                       div_reg [DATA_W+1];
    logic [DATA_W:0]               dv_reg;
    result_t                       res_next;
    result_t                       out_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]             wr_ptr_reg;
    logic [OUT_AW-1:0]             rd_ptr_reg;
    logic [OUT_AW:0]               ocnt_reg;
    logic [OUT_AW:0]               ocnt_next;
    result_t                       head;

    // credit spans the whole pipe and the result queue, so the pipe never stalls
    assign issue = !q_stat.empty && !crd_reg[OUT_AW];
    assign q_pop = issue;
    assign empty = (ocnt_reg == '0);
    assign deq   = pop && !empty;

    always_comb
    begin
        crd_next = crd_reg;
        if (issue && !deq)
        begin
            crd_next = crd_reg + 1'b1;
        end
        else if (!issue && deq)
        begin
            crd_next = crd_reg - 1'b1;
        end
        ocnt_next = ocnt_reg;
        if (dv_reg[DATA_W] && !deq)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (!dv_reg[DATA_W] && deq)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    // partial products: cofactor split into a signed high half and unsigned low half
    always_comb
    begin
        logic [COF_W-1:0]       cof_v;
        logic [5:0][DATA_W-1:0] vals;
        logic [DATA_W-1:0]      val_v;
        vals = {q_item.hrow, q_item.grad};
        for (int j = 0; j < NPROD; j++)
        begin
            cof_v      = q_item.cof[COF_SEL[j]];
            val_v      = vals[VAL_SEL[j]];
            lo_next[j] = $signed({1'b0, cof_v[DATA_W-1:0]}) * $signed(val_v);
            hi_next[j] = $signed(cof_v[COF_W-1:DATA_W]) * $signed(val_v);
        end
    end

    always_comb
    begin
        for (int j = 0; j < NPROD; j++)
        begin
            prod_next[j] = ({{(PROD_W-HI_PW){hi_reg[j][HI_PW-1]}}, hi_reg[j]} << DATA_W)
                         + {{(PROD_W-LO_PW){lo_reg[j][LO_PW-1]}}, lo_reg[j]};
        end
    end

    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            sum_next[s] = {{2{prod_reg[3*s][PROD_W-1]}}, prod_reg[3*s]}
                        + {{2{prod_reg[3*s+1][PROD_W-1]}}, prod_reg[3*s+1]}
                        + {{2{prod_reg[3*s+2][PROD_W-1]}}, prod_reg[3*s+2]};
        end
    end

    // divider set-up: magnitudes, quotient sign, overflow test
    always_comb
    begin
        logic             det_neg;
        logic             nneg;
        logic [MAG_W-1:0] nmag;
        det_neg          = sum_reg[0][SUM_W-1];
        pre_next         = '0;
        pre_next.dmag    = det_neg ? (~sum_reg[0] + 1'b1) : sum_reg[0];
        pre_next.sing    = (sum_reg[0] == '0);
        pre_next.det     = {{(DET_W-(SUM_W-DET_SH)){det_neg}}, sum_reg[0][SUM_W-1:DET_SH]};
        pre_next.sq      = sq3_reg;
        for (int l = 0; l < 3; l++)
        begin
            nneg            = sum_reg[l+1][SUM_W-1];
            nmag            = nneg ? (~sum_reg[l+1] + 1'b1) : sum_reg[l+1];
            pre_next.r[l]   = {nmag, {FRAC_W{1'b0}}};
            pre_next.neg[l] = (nneg == det_neg);
            pre_next.big[l] = ({{(CMP_W-NUM_W){1'b0}}, nmag, {FRAC_W{1'b0}}}
                              >= {pre_next.dmag, {DATA_W{1'b0}}});
        end
    end

    // one quotient bit per lane and one root bit per stage
    for (genvar k = 0; k < DATA_W; k++)
    begin : g_div
        localparam int SH = DATA_W - 1 - k;
        div_st_t nxt;

        always_comb
        begin
            logic [CMP_W-1:0] dsh;
            logic [CMP_W-1:0] rext;
            logic [SQT_W-1:0] tv;
            logic [SQT_W-1:0] trial;
            nxt  = div_reg[k];
            dsh  = {{(CMP_W-MAG_W){1'b0}}, div_reg[k].dmag} << SH;
            for (int l = 0; l < 3; l++)
            begin
                rext = {{(CMP_W-NUM_W){1'b0}}, div_reg[k].r[l]};
                if (rext >= dsh)
                begin
                    nxt.r[l]     = div_reg[k].r[l] - dsh[NUM_W-1:0];
                    nxt.q[l][SH] = 1'b1;
                end
            end
            tv    = {div_reg[k].srem, div_reg[k].sq[SQ_W-1-2*k -: 2]};
            trial = {{(SQT_W-DATA_W-2){1'b0}}, div_reg[k].sroot, 2'b01};
            if (tv >= trial)
            begin
                nxt.srem  = SREM_W'(tv - trial);
                nxt.sroot = {div_reg[k].sroot[DATA_W-2:0], 1'b1};
            end
            else
            begin
                nxt.srem  = tv[SREM_W-1:0];
                nxt.sroot = {div_reg[k].sroot[DATA_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[k+1] <= nxt;
        end
    end

    // saturation and the singular case
    always_comb
    begin
        logic [DATA_W-1:0] lim;
        logic [DATA_W-1:0] mm;
        logic              ovf;
        for (int l = 0; l < 3; l++)
        begin
            lim = div_reg[DATA_W].neg[l] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
            ovf = div_reg[DATA_W].big[l] || (div_reg[DATA_W].q[l] > lim);
            mm  = ovf ? lim : div_reg[DATA_W].q[l];
            res_next.step[l] = div_reg[DATA_W].sing ? '0
                             : (div_reg[DATA_W].neg[l] ? (~mm + 1'b1) : mm);
        end
        res_next.norm = div_reg[DATA_W].sroot;
        res_next.det  = div_reg[DATA_W].sing ? '0 : div_reg[DATA_W].det;
        res_next.sing = div_reg[DATA_W].sing;
    end

    assign head        = out_mem_reg[rd_ptr_reg];
    assign step_x      = head.step[0];
    assign step_y      = head.step[1];
    assign step_z      = head.step[2];
    assign grad_norm   = head.norm;
    assign determinant = head.det;
    assign singular    = head.sing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crd_reg    <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            dv_reg     <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            ocnt_reg   <= '0;
        end
        else
        begin
            crd_reg <= crd_next;
            v1_reg  <= issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            dv_reg  <= {dv_reg[DATA_W-1:0], v3_reg};
            if (dv_reg[DATA_W])
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        sq1_reg    <= q_item.sq;
        prod_reg   <= prod_next;
        sq2_reg    <= sq1_reg;
        sum_reg    <= sum_next;
        sq3_reg    <= sq2_reg;
        div_reg[0] <= pre_next;
        if (dv_reg[DATA_W])
        begin
            out_mem_reg[wr_ptr_reg] <= res_next;
        end
    end

endmodule

@@ rtl/newton_step_sym3x3_top.sv @@
// ----------------------------------------------------------------------------
// newton_step_sym3x3_top
// one newton step -inv(h)*g for a symmetric 3x3 hessian, with |g| and det(h)
// channels: input queue side push/full, a transfer when push and !full;
//   result queue side empty/pop, head result shown while !empty, a transfer
//   when pop and !empty; all values signed q7.16 except the norm (unsigned)
//   and the determinant (q31.16, floor)
// path: input transfer to result visible runs through the front cofactor stages,
//   the queue, 3 multiply/sum stages, a set-up stage, 24 divide/root stages
//   and the result queue
// throughput: one item per cycle while pop keeps pace, set by the fully pipelined
//   radix-2 divider and root, one quotient and one root bit per stage
// reset: clears all queues, credits and valid bits; the data registers are not reset
// stall: pop held low fills the 32-entry result queue; the back then stops
//   draining the mid queue and full rises once the front credit is used up
// a zero determinant gives zero step, zero determinant and singular high
// ----------------------------------------------------------------------------
`include "newton_step_sym3x3_top_assert.svh"

module newton_step_sym3x3_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [nsym_pkg::DATA_W-1:0] grad_x,
    input  logic signed [nsym_pkg::DATA_W-1:0] grad_y,
    input  logic signed [nsym_pkg::DATA_W-1:0] grad_z,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_xx,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_xy,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_xz,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_yy,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_yz,
    input  logic signed [nsym_pkg::DATA_W-1:0] hess_zz,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [nsym_pkg::DATA_W-1:0] step_x,
    output logic signed [nsym_pkg::DATA_W-1:0] step_y,
    output logic signed [nsym_pkg::DATA_W-1:0] step_z,
    output logic [nsym_pkg::DATA_W-1:0]        grad_norm,
    output logic signed [nsym_pkg::DET_W-1:0]  determinant,
    output logic                               singular
);
    import nsym_pkg::*;

    // front to queue
    logic        mid_push;
    mid_item_t   mid_in;
    // queue to back
    logic        mid_pop;
    mid_item_t   mid_out;
    queue_stat_t mid_stat;

    // front: cofactors and squared norm, two stages
    nsym_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .grad_x   (grad_x),
        .grad_y   (grad_y),
        .grad_z   (grad_z),
        .hess_xx  (hess_xx),
        .hess_xy  (hess_xy),
        .hess_xz  (hess_xz),
        .hess_yy  (hess_yy),
        .hess_yz  (hess_yz),
        .hess_zz  (hess_zz),
        .mid_pop  (mid_pop),
        .mid_push (mid_push),
        .mid_item (mid_in)
    );

    // decoupling queue, lets front and back stall on their own
    nsym_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (mid_push),
        .item_in  (mid_in),
        .pop      (mid_pop),
        .item_out (mid_out),
        .stat     (mid_stat)
    );

    // back: determinant, adjugate times gradient, divide, root, result queue
    nsym_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (mid_out),
        .q_stat      (mid_stat),
        .q_pop       (mid_pop),
        .pop         (pop),
        .empty       (empty),
        .step_x      (step_x),
        .step_y      (step_y),
        .step_z      (step_z),
        .grad_norm   (grad_norm),
        .determinant (determinant),
        .singular    (singular)
    );

    // a singular result carries a zero step and zero determinant
    `NSYM_ASSERT(a_sing_zero, (!empty && singular) |-> (step_x == '0 && step_y == '0 && step_z == '0 && determinant == '0), "singular result with nonzero step")
    // the front credit must keep the mid queue from overflowing
    `NSYM_ASSERT(a_mid_no_ovf, !(mid_push && mid_stat.full), "mid queue written while full")
    // a lone write into the mid queue makes it non-empty
    `NSYM_ASSERT_NEXT(a_mid_fill, mid_push && !mid_pop, !mid_stat.empty, "mid queue lost an item")

endmodule
